### hw/rtl/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg: shared types and constants of the cron schedule matcher
// Beat layouts, command and status codes, queue sizing, and the
// per-entry time match function.
// ----------------------------------------------------------------------------
package csm_pkg;

   localparam int ENTRY_COUNT = 16;
   localparam int SLOT_W      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam int HANDLE_W    = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] MDAY_ALL = 32'hFFFF_FFFE;
   localparam logic [7:0]  WDAY_ALL = 8'hFE;

   localparam logic [2:0] CMD_ADD_DISABLED = 3'd0;
   localparam logic [2:0] CMD_ADD_ENABLED  = 3'd1;
   localparam logic [2:0] CMD_REMOVE       = 3'd2;
   localparam logic [2:0] CMD_ENABLE       = 3'd3;
   localparam logic [2:0] CMD_DISABLE      = 3'd4;
   localparam logic [2:0] CMD_TICK         = 3'd5;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_BAD     = 3'd3;
   localparam logic [2:0] ST_FIRED   = 3'd4;
   localparam logic [2:0] ST_NOMATCH = 3'd5;

   typedef struct packed {
      logic [2:0]  command;
      logic [6:0]  handle;
      logic [59:0] minute_bits;
      logic [23:0] hour_bits;
      logic [31:0] mday_bits;
      logic [12:0] month_mask;
      logic [7:0]  wday_bits;
      logic [5:0]  now_minute;
      logic [4:0]  now_hour;
      logic [4:0]  now_mday;
      logic [3:0]  now_month;
      logic [2:0]  now_wday;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [HANDLE_W-1:0] result_handle;
      logic                last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_REPORT,
      OP_ADD,
      OP_MODIFY,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [2:0]        status;
      logic [SLOT_W-1:0] slot;
      req_type           req;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [59:0] minute;
      logic [23:0] hour;
      logic [31:0] mday;
      logic [12:0] month;
      logic [7:0]  wday;
   } entry_type;

   function automatic logic entry_match(entry_type e, req_type r);
      logic [63:0] mi;
      logic [31:0] hr;
      logic [15:0] mo;
      logic        md_any;
      logic        wd_any;
      logic        md_hit;
      logic        wd_hit;
      logic        base;
      logic        day;
      mi     = {4'b0, e.minute};
      hr     = {8'b0, e.hour};
      mo     = {3'b0, e.month};
      md_any = (e.mday & MDAY_ALL) == MDAY_ALL;
      wd_any = (e.wday & WDAY_ALL) == WDAY_ALL;
      md_hit = e.mday[r.now_mday];
      wd_hit = e.wday[r.now_wday];
      base   = mi[r.now_minute] & hr[r.now_hour] & mo[r.now_month];
      if (md_any && wd_any) begin
         day = 1'b1;
      end else if (md_any) begin
         day = wd_hit;
      end else if (wd_any) begin
         day = md_hit;
      end else begin
         day = md_hit | wd_hit;
      end
      return base & day;
   endfunction

endpackage

### hw/rtl/csm_front.sv
// ----------------------------------------------------------------------------
// csm_front: command decode and classification
// Checks masks and handle range, resolves the slot and tags each beat
// with the operation the back end must carry out.
// ----------------------------------------------------------------------------
module csm_front (
   input  logic             start,
   input  logic             busy,
   input  csm_pkg::req_type req_data,
   output logic             push,
   output csm_pkg::item_type item
);
   import csm_pkg::*;

   logic known;
   logic [HANDLE_W-1:0] handle_m1;

   assign handle_m1 = req_data.handle - HANDLE_W'(1);

   always_comb begin
      item.req    = req_data;
      item.slot   = handle_m1[SLOT_W-1:0];
      item.status = ST_OK;
      item.op     = OP_REPORT;
      known       = 1'b1;
      case (req_data.command)
         CMD_ADD_DISABLED, CMD_ADD_ENABLED: begin
            if (req_data.minute_bits == '0 || req_data.hour_bits == '0 ||
                req_data.mday_bits == '0 || req_data.month_mask == '0 ||
                req_data.wday_bits == '0) begin
               item.status = ST_EMPTY;
            end else begin
               item.op = OP_ADD;
            end
         end
         CMD_REMOVE, CMD_ENABLE, CMD_DISABLE: begin
            if (req_data.handle == '0 || req_data.handle > HANDLE_W'(ENTRY_COUNT)) begin
               item.status = ST_BAD;
            end else begin
               item.op = OP_MODIFY;
            end
         end
         CMD_TICK: begin
            item.op = OP_TICK;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   assign push = start && !busy && known;

endmodule

### hw/rtl/csm_queue.sv
// ----------------------------------------------------------------------------
// csm_queue: short FIFO between front and back
// Holds classified beats so the front keeps taking commands while a
// tick scan is running, until the queue is full.
// ----------------------------------------------------------------------------
module csm_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  csm_pkg::item_type         push_item,
   input  logic                      pop,
   output csm_pkg::item_type         head,
   output csm_pkg::queue_status_type qstat
);
   import csm_pkg::*;

   item_type          slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head        = slots_ff[rd_ptr_ff];
   assign qstat.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign qstat.empty = count_ff == '0;

endmodule

### hw/rtl/csm_back.sv
// ----------------------------------------------------------------------------
// csm_back: entry table and command execution
// Owns the flags and the mask memory, applies add/remove/enable/disable
// and scans the table one slot per cycle on a tick.
// ----------------------------------------------------------------------------
module csm_back (
   input  logic                      clock,
   input  logic                      reset,
   input  csm_pkg::item_type         head,
   input  csm_pkg::queue_status_type qstat,
   output logic                      pop,
   output logic                      rsp_valid,
   output csm_pkg::rsp_type          rsp_data
);
   import csm_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FLUSH
   } state_type;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRY_COUNT - 1);

   state_type            state_ff, state_in;
   logic [ENTRY_COUNT-1:0] used_ff, used_in;
   logic [ENTRY_COUNT-1:0] enabled_ff, enabled_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   req_type              now_ff, now_in;
   logic [SLOT_W-1:0]    scan_addr_ff, scan_addr_in;
   logic                 issue_done_ff, issue_done_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [SLOT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                 rd_elig_ff, rd_elig_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]    pend_idx_ff, pend_idx_in;

   entry_type            mem [ENTRY_COUNT];
   entry_type            rd_entry_ff;

   logic                 wr_en;
   logic                 issue;
   logic                 free_found;
   logic [SLOT_W-1:0]    free_slot;
   logic                 hit;

   function automatic logic [HANDLE_W-1:0] to_handle(logic [SLOT_W-1:0] s);
      return HANDLE_W'(s) + HANDLE_W'(1);
   endfunction

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   assign pop   = (state_ff == S_IDLE) && !qstat.empty;
   assign issue = (state_ff == S_SCAN) && !issue_done_ff;
   assign hit   = rd_valid_ff && rd_elig_ff && entry_match(rd_entry_ff, now_ff);

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      enabled_in    = enabled_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      now_in        = now_ff;
      scan_addr_in  = scan_addr_ff;
      issue_done_in = issue_done_ff;
      rd_valid_in   = issue;
      rd_idx_in     = scan_addr_ff;
      rd_elig_in    = used_ff[scan_addr_ff] & enabled_ff[scan_addr_ff];
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      wr_en         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               rsp_in.last          = 1'b1;
               rsp_in.result_handle = '0;
               rsp_in.status        = ST_OK;
               case (head.op)
                  OP_REPORT: begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = head.status;
                  end
                  OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (free_found) begin
                        wr_en                 = 1'b1;
                        used_in[free_slot]    = 1'b1;
                        enabled_in[free_slot] = head.req.command == CMD_ADD_ENABLED;
                        rsp_in.result_handle  = to_handle(free_slot);
                     end else begin
                        rsp_in.status = ST_FULL;
                     end
                  end
                  OP_MODIFY: begin
                     rsp_valid_in = 1'b1;
                     if (!used_ff[head.slot]) begin
                        rsp_in.status = ST_BAD;
                     end else begin
                        case (head.req.command)
                           CMD_REMOVE: used_in[head.slot]    = 1'b0;
                           CMD_ENABLE: enabled_in[head.slot] = 1'b1;
                           default:    enabled_in[head.slot] = 1'b0;
                        endcase
                     end
                  end
                  default: begin
                     now_in        = head.req;
                     scan_addr_in  = '0;
                     issue_done_in = 1'b0;
                     pend_valid_in = 1'b0;
                     state_in      = S_SCAN;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue) begin
               if (scan_addr_ff == LAST_SLOT) begin
                  issue_done_in = 1'b1;
               end else begin
                  scan_addr_in = scan_addr_ff + SLOT_W'(1);
               end
            end
            if (hit) begin
               if (pend_valid_ff) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.status        = ST_FIRED;
                  rsp_in.result_handle = to_handle(pend_idx_ff);
                  rsp_in.last          = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_idx_in   = rd_idx_ff;
            end
            if (rd_valid_ff && rd_idx_ff == LAST_SLOT) begin
               state_in = S_FLUSH;
            end
         end
         default: begin
            rsp_valid_in = 1'b1;
            rsp_in.last  = 1'b1;
            if (pend_valid_ff) begin
               rsp_in.status        = ST_FIRED;
               rsp_in.result_handle = to_handle(pend_idx_ff);
            end else begin
               rsp_in.status        = ST_NOMATCH;
               rsp_in.result_handle = '0;
            end
            pend_valid_in = 1'b0;
            state_in      = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         enabled_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         issue_done_ff <= 1'b1;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         enabled_ff    <= enabled_in;
         rsp_valid_ff  <= rsp_valid_in;
         issue_done_ff <= issue_done_in;
         rd_valid_ff   <= rd_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      rsp_ff       <= rsp_in;
      now_ff       <= now_in;
      scan_addr_ff <= scan_addr_in;
      rd_idx_ff    <= rd_idx_in;
      rd_elig_ff   <= rd_elig_in;
      pend_idx_ff  <= pend_idx_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[free_slot] <= '{minute: head.req.minute_bits,
                             hour:   head.req.hour_bits,
                             mday:   head.req.mday_bits,
                             month:  head.req.month_mask,
                             wday:   head.req.wday_bits};
      end
      if (issue) begin
         rd_entry_ff <= mem[scan_addr_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/cron_schedule_matcher_unit.sv
// ----------------------------------------------------------------------------
// cron_schedule_matcher_unit: table of cron entries with minute-tick matching
// Commands go in on the req_ channel, one beat per command; results come
// out on the rsp_ channel, one beat per cycle, flagged by rsp_valid.
//
// A command beat is taken at a rising edge with start high and busy low.
// busy rises only when the two-beat command queue is full.
// Add, remove, enable, disable and rejected commands give one result beat;
// with the back end idle it goes from the command queue into the registered
// response and is taken by the receiver while rsp_valid is high. The back end
// finishes one of them per cycle while no tick scan is running.
// A tick scans the table one slot per cycle through the registered mask
// memory read port, giving every fired handle in slot order, the final
// beat marked last, or one no-match beat.
// Unknown command codes are taken and dropped without a result.
// Result beats cannot be held off; the receiver must take each one in the
// cycle it is shown. Reset empties the queue and clears all used and
// enabled flags; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module cron_schedule_matcher_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  csm_pkg::req_type req_data,
   output logic             rsp_valid,
   output csm_pkg::rsp_type rsp_data
);
   import csm_pkg::*;

   logic             push;
   logic             pop;
   item_type         push_item;
   item_type         head;
   queue_status_type qstat;

   assign busy = qstat.full;

   csm_front u_front (
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .push     (push),
      .item     (push_item)
   );

   csm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   csm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_fired_has_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FIRED |-> rsp_data.result_handle != '0)
      else $error("fired beat without handle");

   a_nomatch_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_NOMATCH |-> rsp_data.last)
      else $error("no-match beat not last");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("push into full queue");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("pop from empty queue");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("not idle after reset");

endmodule

### dv/cron_schedule_matcher_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cron_schedule_matcher_unit_test: self-checking bench for the cron matcher
// Drives add, remove, enable, disable, minute-tick and reserved commands with random
// gaps, keeps its own copy of the entry table to predict every result beat,
// and checks each rsp_ beat in order against the predicted ones.
// ----------------------------------------------------------------------------
module cron_schedule_matcher_unit_test;
   import csm_pkg::*;

   localparam logic [2:0] CMD_RESERVED_LO = 3'd6;
   localparam logic [2:0] CMD_RESERVED_HI = 3'd7;
   localparam int RANDOM_ITEMS = 386;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int TAIL_CYCLES  = ENTRY_COUNT + 8;

   localparam logic [63:0] MINUTE_VALID = 64'h0FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] HOUR_VALID   = 64'h0000_0000_00FF_FFFF;
   localparam logic [63:0] MONTH_VALID  = 64'h0000_0000_0000_1FFE;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   logic    rsp_valid;
   req_type req_data;
   rsp_type rsp_data;

   cron_schedule_matcher_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   class cron_table_model;
      bit        used [ENTRY_COUNT];
      bit        enabled [ENTRY_COUNT];
      entry_type masks [ENTRY_COUNT];
      rsp_type   pending [$];
      int        errors;

      function void queue_result(logic [2:0] status, int h, bit last);
         rsp_type b;
         b.status        = status;
         b.result_handle = h[HANDLE_W-1:0];
         b.last          = last;
         pending.push_back(b);
      endfunction

      function bit slot_hits(int i, req_type r);
         logic [63:0] mi;
         logic [31:0] hr;
         logic [31:0] mo;
         logic [31:0] md;
         logic [7:0]  wd;
         bit          md_any;
         bit          wd_any;
         bit          md_hit;
         bit          wd_hit;
         mi = {4'b0, masks[i].minute};
         hr = {8'b0, masks[i].hour};
         mo = {19'b0, masks[i].month};
         md = masks[i].mday;
         wd = masks[i].wday;
         if (!mi[r.now_minute] || !hr[r.now_hour] || !mo[r.now_month]) return 1'b0;
         md_any = (md & MDAY_ALL) == MDAY_ALL;
         wd_any = (wd & WDAY_ALL) == WDAY_ALL;
         md_hit = md[r.now_mday];
         wd_hit = wd[r.now_wday];
         if (md_any && wd_any) return 1'b1;
         if (md_any) return wd_hit;
         if (wd_any) return md_hit;
         return md_hit || wd_hit;
      endfunction

      function void note_command(req_type r);
         int slot;
         int hits [$];
         case (r.command)
            CMD_ADD_DISABLED, CMD_ADD_ENABLED: begin
               if (r.minute_bits == '0 || r.hour_bits == '0 || r.mday_bits == '0 ||
                   r.month_mask == '0 || r.wday_bits == '0) begin
                  queue_result(ST_EMPTY, 0, 1'b1);
               end else begin
                  slot = -1;
                  for (int i = 0; i < ENTRY_COUNT; i++) begin
                     if (!used[i] && slot < 0) slot = i;
                  end
                  if (slot < 0) begin
                     queue_result(ST_FULL, 0, 1'b1);
                  end else begin
                     used[slot]    = 1'b1;
                     enabled[slot] = (r.command == CMD_ADD_ENABLED);
                     masks[slot]   = {r.minute_bits, r.hour_bits, r.mday_bits,
                                      r.month_mask, r.wday_bits};
                     queue_result(ST_OK, slot + 1, 1'b1);
                  end
               end
            end
            CMD_REMOVE, CMD_ENABLE, CMD_DISABLE: begin
               slot = int'(r.handle) - 1;
               if (slot < 0 || slot >= ENTRY_COUNT) begin
                  queue_result(ST_BAD, 0, 1'b1);
               end else if (!used[slot]) begin
                  queue_result(ST_BAD, 0, 1'b1);
               end else begin
                  if (r.command == CMD_REMOVE) used[slot] = 1'b0;
                  else if (r.command == CMD_ENABLE) enabled[slot] = 1'b1;
                  else enabled[slot] = 1'b0;
                  queue_result(ST_OK, 0, 1'b1);
               end
            end
            CMD_TICK: begin
               for (int i = 0; i < ENTRY_COUNT; i++) begin
                  if (used[i] && enabled[i] && slot_hits(i, r)) hits.push_back(i + 1);
               end
               if (hits.size() == 0) queue_result(ST_NOMATCH, 0, 1'b1);
               foreach (hits[k]) queue_result(ST_FIRED, hits[k], k == hits.size() - 1);
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected beat status=%0d handle=%0d last=%0d",
                                      got.status, got.result_handle, got.last));
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status || got.result_handle !== want.result_handle ||
             got.last !== want.last) begin
            report_mismatch($sformatf("status %0d/%0d handle %0d/%0d last %0d/%0d (got/exp)",
                                      got.status, want.status, got.result_handle,
                                      want.result_handle, got.last, want.last));
         end
      endtask
   endclass

   cron_table_model cron_table;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) cron_table.check_result(rsp_data);
   end

   task automatic send_beat(req_type r);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      cron_table.note_command(r);
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   function automatic int pick_gap(bit quiet);
      int roll;
      roll = $urandom_range(99, 0);
      if (quiet || roll < 55) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      return $urandom_range(40, 6);
   endfunction

   function automatic req_type random_beat();
      logic [191:0] raw;
      for (int k = 0; k < 6; k++) raw[k*32 +: 32] = $urandom;
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic logic [63:0] random_mask(int w, logic [63:0] valid_all, bit wide);
      logic [63:0] full;
      logic [63:0] v;
      full = (64'd1 << w) - 64'd1;
      if (wide) return full;
      case ($urandom_range(9, 0))
         0, 1:    v = full;
         2, 3:    v = valid_all;
         4, 5:    v = 64'd1 << $urandom_range(w - 1, 0);
         6, 7:    v = {$urandom, $urandom};
         default: v = {$urandom, $urandom} & {$urandom, $urandom};
      endcase
      v &= full;
      if (v == '0) v = valid_all;
      return v;
   endfunction

   function automatic int pick_set_bit(logic [63:0] m, int w);
      int first;
      int idx;
      first = $urandom_range(w - 1, 0);
      for (int k = 0; k < w; k++) begin
         idx = (first + k) % w;
         if (m[idx]) return idx;
      end
      return first;
   endfunction

   function automatic req_type add_cmd(logic [2:0] cmd, logic [59:0] mi, logic [23:0] hr,
                                       logic [31:0] md, logic [12:0] mo, logic [7:0] wd);
      req_type r;
      r             = random_beat();
      r.command     = cmd;
      r.minute_bits = mi;
      r.hour_bits   = hr;
      r.mday_bits   = md;
      r.month_mask  = mo;
      r.wday_bits   = wd;
      return r;
   endfunction

   function automatic req_type modify_cmd(logic [2:0] cmd, logic [6:0] h);
      req_type r;
      r         = random_beat();
      r.command = cmd;
      r.handle  = h;
      return r;
   endfunction

   function automatic req_type tick_at(logic [5:0] mi, logic [4:0] hr, logic [4:0] md,
                                       logic [3:0] mo, logic [2:0] wd);
      req_type r;
      r            = random_beat();
      r.command    = CMD_TICK;
      r.now_minute = mi;
      r.now_hour   = hr;
      r.now_mday   = md;
      r.now_month  = mo;
      r.now_wday   = wd;
      return r;
   endfunction

   function automatic logic [6:0] pick_handle();
      int live [$];
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         if (cron_table.used[i]) live.push_back(i + 1);
      end
      if (live.size() > 0 && $urandom_range(3, 0) != 0)
         return 7'(live[$urandom_range(live.size() - 1, 0)]);
      return 7'($urandom_range(127, 0));
   endfunction

   function automatic void aim_tick(ref req_type r);
      int        armed [$];
      int        s;
      entry_type e;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         if (cron_table.used[i] && cron_table.enabled[i]) armed.push_back(i);
      end
      if (armed.size() == 0 || $urandom_range(3, 0) == 0) return;
      s = armed[$urandom_range(armed.size() - 1, 0)];
      e = cron_table.masks[s];
      r.now_minute = 6'(pick_set_bit({4'b0, e.minute}, 60));
      r.now_hour   = 5'(pick_set_bit({40'b0, e.hour}, 24));
      r.now_mday   = 5'(pick_set_bit({32'b0, e.mday}, 32));
      r.now_month  = 4'(pick_set_bit({51'b0, e.month}, 13));
      r.now_wday   = 3'(pick_set_bit({56'b0, e.wday}, 8));
      // knock one day field off so the either-day rule gets exercised
      if ($urandom_range(3, 0) == 0) begin
         if ($urandom_range(1, 0) != 0) r.now_mday = 5'($urandom);
         else r.now_wday = 3'($urandom);
      end
   endfunction

   initial begin
      req_type     r;
      logic [63:0] m;
      bit          quiet;
      bit          wide;
      int          phase;
      int          roll;
      int          add_cut;
      int          rem_cut;
      int          waited;

      cron_table = new();
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, each empty mask, bad handles, day rules, unknown codes, reuse
      send_beat(tick_at(6'd0, 5'd0, 5'd1, 4'd1, 3'd1));
      for (int k = 0; k < 5; k++) begin
         r = add_cmd(CMD_ADD_ENABLED, '1, '1, '1, '1, '1);
         case (k)
            0: r.minute_bits = '0;
            1: r.hour_bits   = '0;
            2: r.mday_bits   = '0;
            3: r.month_mask  = '0;
            default: r.wday_bits = '0;
         endcase
         send_beat(r);
         idle_cycles(pick_gap(1'b0));
      end
      send_beat(modify_cmd(CMD_REMOVE, 7'd0));
      send_beat(modify_cmd(CMD_ENABLE, 7'(ENTRY_COUNT + 1)));
      send_beat(modify_cmd(CMD_DISABLE, 7'h7F));
      send_beat(modify_cmd(CMD_DISABLE, 7'd3));
      send_beat(add_cmd(CMD_ADD_ENABLED, '1, '1, '1, '1, '1));
      send_beat(add_cmd(CMD_ADD_DISABLED, 60'd1 << 59, 24'd1 << 23, 32'd1, 13'd1 << 12, 8'd1));
      send_beat(tick_at(6'd59, 5'd23, 5'd31, 4'd12, 3'd7));
      send_beat(modify_cmd(CMD_ENABLE, 7'd2));
      send_beat(tick_at(6'd59, 5'd23, 5'd0, 4'd12, 3'd5));
      send_beat(tick_at(6'd63, 5'd31, 5'd31, 4'd15, 3'd7));
      send_beat(modify_cmd(CMD_RESERVED_LO, 7'd1));
      send_beat(modify_cmd(CMD_RESERVED_HI, 7'd2));
      send_beat(modify_cmd(CMD_DISABLE, 7'd1));
      send_beat(tick_at(6'd59, 5'd23, 5'd1, 4'd12, 3'd0));
      send_beat(modify_cmd(CMD_REMOVE, 7'd1));
      send_beat(add_cmd(CMD_ADD_DISABLED, '1, '1, MDAY_ALL, 13'h1FFE, WDAY_ALL));
      send_beat(modify_cmd(CMD_REMOVE, 7'd2));
      send_beat(modify_cmd(CMD_REMOVE, 7'd2));
      idle_cycles(pick_gap(1'b0));

      quiet = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) quiet = ($urandom_range(3, 0) == 0);
         phase   = (n / 60) % 3;
         add_cut = (phase == 1) ? 45 : (phase == 2) ? 12 : 28;
         rem_cut = (phase == 1) ? 5 : (phase == 2) ? 25 : 12;
         roll    = $urandom_range(99, 0);
         r       = random_beat();
         if (roll < add_cut) begin
            r.command = ($urandom_range(1, 0) != 0) ? CMD_ADD_ENABLED : CMD_ADD_DISABLED;
            wide = (phase == 1) && ($urandom_range(1, 0) != 0);
            m = random_mask(60, MINUTE_VALID, wide);
            r.minute_bits = m[59:0];
            m = random_mask(24, HOUR_VALID, wide);
            r.hour_bits = m[23:0];
            m = random_mask(32, {32'b0, MDAY_ALL}, wide);
            r.mday_bits = m[31:0];
            m = random_mask(13, MONTH_VALID, wide);
            r.month_mask = m[12:0];
            m = random_mask(8, {56'b0, WDAY_ALL}, wide);
            r.wday_bits = m[7:0];
            if ($urandom_range(15, 0) == 0) begin
               case ($urandom_range(4, 0))
                  0: r.minute_bits = '0;
                  1: r.hour_bits   = '0;
                  2: r.mday_bits   = '0;
                  3: r.month_mask  = '0;
                  default: r.wday_bits = '0;
               endcase
            end
         end else if (roll < add_cut + rem_cut + 18) begin
            if (roll < add_cut + rem_cut) r.command = CMD_REMOVE;
            else if (roll < add_cut + rem_cut + 10) r.command = CMD_ENABLE;
            else r.command = CMD_DISABLE;
            r.handle = pick_handle();
         end else if (roll < 97) begin
            r.command = CMD_TICK;
            aim_tick(r);
         end else begin
            r.command = ($urandom_range(1, 0) != 0) ? CMD_RESERVED_HI : CMD_RESERVED_LO;
         end
         send_beat(r);
         idle_cycles(pick_gap(quiet));
      end
      idle_cycles(1);

      waited = 0;
      while (cron_table.pending.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (cron_table.pending.size() != 0)
         cron_table.report_mismatch($sformatf("%0d result beats never arrived",
                                              cron_table.pending.size()));
      if (cron_table.errors == 0) begin
         $display("[cron_schedule_matcher_unit] OK");
      end else begin
         $display("[cron_schedule_matcher_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[cron_schedule_matcher_unit] ERROR");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/csm_pkg.sv
hw/rtl/csm_front.sv
hw/rtl/csm_queue.sv
hw/rtl/csm_back.sv
hw/rtl/cron_schedule_matcher_unit.sv
dv/cron_schedule_matcher_unit_test.sv
